// File: design/wtol_pkg.sv
// shared types and constants for the lagrange wavetable oscillator
// no dependencies; used by wavetable_oscillator_lagrange
`timescale 1ns / 1ps

package wtol_pkg;

  localparam int SampleW   = 24;
  localparam int PhaseW    = 32;
  localparam int FracW     = 16;
  localparam int FmixW     = 16;
  localparam int LmixW     = 17;
  localparam int FrameSize = 256;
  localparam int NumFrames = 4;
  localparam int MaxLevel  = 7;
  localparam int IdxW      = $clog2(FrameSize);
  localparam int FrameW    = $clog2(NumFrames);
  localparam int LevelW    = $clog2(MaxLevel + 1);
  localparam int MemDepth  = FrameSize * NumFrames * (MaxLevel + 1);
  localparam int AddrW     = $clog2(MemDepth);
  localparam int AccW      = 32;
  localparam int OpW       = AccW + 1;
  localparam int ProdW     = 2 * OpW;
  localparam int CfgIdxW   = 3;

  // divide by six: floor(n / 6) = (n * ceil(2^34 / 6)) >> 34 for any 32-bit n
  localparam logic [OpW-1:0] Div6Mul   = 33'h0_AAAA_AAAB;
  localparam int             Div6Shift = 34;
  // bias that keeps the dividend positive, a multiple of six
  localparam logic [AccW-1:0] Div6Bias  = 32'd1610612736;
  localparam logic [AccW-1:0] Div6BiasQ = 32'd268435456;
  localparam logic [LmixW-1:0] LmixOne  = 17'h1_0000;

  typedef logic signed [AccW-1:0] acc_t;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_PHASE = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE    = 3'd0,
    REG_PHASE_INC = 3'd1,
    REG_FRAME_LO  = 3'd2,
    REG_FRAME_HI  = 3'd3,
    REG_FRAME_MIX = 3'd4,
    REG_LEVEL_LO  = 3'd5,
    REG_LEVEL_HI  = 3'd6,
    REG_LEVEL_MIX = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_DMUL,
    ST_DIV,
    ST_MMUL,
    ST_MADD,
    ST_OUT
  } state_e;

endpackage

// File: design/wavetable_oscillator_lagrange.sv
// wavetable oscillator: cubic lagrange interpolation, frame morph, level crossfade
// depends on wtol_pkg
`timescale 1ns / 1ps

// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o  | func, frame_sel, level_sel, sample_index,
//         |           |                          | write_data, phase_value
// out     | output    | out_valid_o / out_stall_i| sample_out
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// a table write, a phase set or an unused func completes on its transfer and keeps the input free
// an enabled tick, after its transfer, makes 16 table reads from the single memory port and
// lands the last word, then runs four groups of three horner steps and a divide-by-six on
// the one shared multiplier, then three mixing steps and an output state that waits for output room
// a disabled tick goes straight to the output state; in_stall_o is high until the tick is done
// reset clears the phase, the registers and control; the table holds garbage until written
// a result waits in the output register while the next item is taken

module wavetable_oscillator_lagrange (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input item channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         func_i,
  input  logic [wtol_pkg::FrameW-1:0]        frame_sel_i,
  input  logic [wtol_pkg::LevelW-1:0]        level_sel_i,
  input  logic [wtol_pkg::IdxW-1:0]          sample_index_i,
  input  logic signed [wtol_pkg::SampleW-1:0] write_data_i,
  input  logic [wtol_pkg::PhaseW-1:0]        phase_value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [wtol_pkg::SampleW-1:0] sample_out_o,
  // register write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wtol_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  // configuration registers
  logic                          enable_q;
  logic [wtol_pkg::PhaseW-1:0]   phase_inc_q;
  logic [wtol_pkg::FrameW-1:0]   frame_lo_q, frame_hi_q;
  logic [wtol_pkg::FmixW-1:0]    frame_mix_q;
  logic [wtol_pkg::LevelW-1:0]   level_lo_q, level_hi_q;
  logic [wtol_pkg::LmixW-1:0]    level_mix_q;

  // datapath state
  logic [wtol_pkg::PhaseW-1:0]   phase_q;
  logic [wtol_pkg::IdxW-1:0]     idx_q;
  logic [wtol_pkg::FracW-1:0]    frac_q;
  wtol_pkg::state_e              state_q, state_d;
  logic [4:0]                    rd_cnt_q;
  logic [1:0]                    grp_q;
  logic [1:0]                    hstep_q;
  logic [1:0]                    mstep_q;
  logic signed [wtol_pkg::SampleW-1:0] x_q [16];
  wtol_pkg::acc_t                acc_q;
  logic signed [wtol_pkg::ProdW-1:0] prod_q;
  wtol_pkg::acc_t                r0_q, r1_q, r2_q, r3_q, fin_q;
  logic                          out_valid_q;
  logic signed [wtol_pkg::SampleW-1:0] sample_q;

  logic signed [wtol_pkg::SampleW-1:0] mem_q [wtol_pkg::MemDepth];

  logic in_xfer, cfg_xfer, out_free;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != wtol_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_out_o = sample_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      phase_inc_q <= '0;
      frame_lo_q  <= '0;
      frame_hi_q  <= '0;
      frame_mix_q <= '0;
      level_lo_q  <= '0;
      level_hi_q  <= '0;
      level_mix_q <= '0;
    end else if (cfg_xfer) begin
      case (wtol_pkg::cfg_reg_e'(cfg_index_i))
        wtol_pkg::REG_ENABLE:    enable_q    <= cfg_data_i[0];
        wtol_pkg::REG_PHASE_INC: phase_inc_q <= cfg_data_i;
        wtol_pkg::REG_FRAME_LO:  frame_lo_q  <= cfg_data_i[wtol_pkg::FrameW-1:0];
        wtol_pkg::REG_FRAME_HI:  frame_hi_q  <= cfg_data_i[wtol_pkg::FrameW-1:0];
        wtol_pkg::REG_FRAME_MIX: frame_mix_q <= cfg_data_i[wtol_pkg::FmixW-1:0];
        wtol_pkg::REG_LEVEL_LO:  level_lo_q  <= cfg_data_i[wtol_pkg::LevelW-1:0];
        wtol_pkg::REG_LEVEL_HI:  level_hi_q  <= cfg_data_i[wtol_pkg::LevelW-1:0];
        wtol_pkg::REG_LEVEL_MIX: level_mix_q <= cfg_data_i[wtol_pkg::LmixW-1:0];
        default: ;
      endcase
    end
  end

  // table read address: group picks level (bit 1) and frame (bit 0), tap k reads idx+k-1
  logic [1:0]                  rd_grp, rd_tap;
  logic [wtol_pkg::LevelW-1:0] rd_level;
  logic [wtol_pkg::FrameW-1:0] rd_frame;
  logic [wtol_pkg::IdxW-1:0]   rd_idx;
  logic [wtol_pkg::AddrW-1:0]  rd_addr, wr_addr;
  logic                        rd_en;

  assign rd_grp   = rd_cnt_q[3:2];
  assign rd_tap   = rd_cnt_q[1:0];
  assign rd_level = rd_grp[1] ? level_hi_q : level_lo_q;
  assign rd_frame = rd_grp[0] ? frame_hi_q : frame_lo_q;
  assign rd_idx   = idx_q + wtol_pkg::IdxW'(rd_tap) - wtol_pkg::IdxW'(1);
  assign rd_addr  = {rd_level, rd_frame, rd_idx};
  assign wr_addr  = {level_sel_i, frame_sel_i, sample_index_i};
  assign rd_en    = (state_q == wtol_pkg::ST_READ) && !rd_cnt_q[4];

  logic mem_we;
  assign mem_we = in_xfer && (func_i == wtol_pkg::FUNC_WRITE);

  // table memory, reads land in the tap shift line
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= write_data_i;
    end
    if (rd_en) begin
      for (int i = 0; i < 15; i++) x_q[i] <= x_q[i+1];
      x_q[15] <= mem_q[rd_addr];
    end else if (state_q == wtol_pkg::ST_DIV) begin
      // retire the finished group of four taps
      for (int i = 0; i < 12; i++) x_q[i] <= x_q[i+4];
    end
  end

  // lagrange coefficients times six for the group at the head of the shift line
  wtol_pkg::acc_t c3, c2, c1, c0, csel;
  always_comb begin
    wtol_pkg::acc_t xm1, x0, x1, x2;
    xm1 = wtol_pkg::acc_t'(x_q[0]);
    x0  = wtol_pkg::acc_t'(x_q[1]);
    x1  = wtol_pkg::acc_t'(x_q[2]);
    x2  = wtol_pkg::acc_t'(x_q[3]);
    c3 = (x2 - xm1) + 3 * (x0 - x1);
    c2 = 3 * (xm1 + x1) - 6 * x0;
    c1 = 6 * x1 - 2 * xm1 - 3 * x0 - x2;
    c0 = 6 * x0;
    case (hstep_q)
      2'd0:    csel = c2;
      2'd1:    csel = c1;
      default: csel = c0;
    endcase
  end

  // mix operands
  logic [wtol_pkg::LmixW-1:0] lmix_sat, mix_w;
  wtol_pkg::acc_t             mix_lo, mix_hi;
  assign lmix_sat = (level_mix_q > wtol_pkg::LmixOne) ? wtol_pkg::LmixOne : level_mix_q;
  always_comb begin
    case (mstep_q)
      2'd0: begin
        mix_lo = r0_q;
        mix_hi = r1_q;
        mix_w  = {1'b0, frame_mix_q};
      end
      2'd1: begin
        mix_lo = r2_q;
        mix_hi = r3_q;
        mix_w  = {1'b0, frame_mix_q};
      end
      default: begin
        mix_lo = r0_q;
        mix_hi = r2_q;
        mix_w  = lmix_sat;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wtol_pkg::ST_IDLE: begin
        if (in_xfer && func_i == wtol_pkg::FUNC_TICK) begin
          state_d = enable_q ? wtol_pkg::ST_READ : wtol_pkg::ST_OUT;
        end
      end
      wtol_pkg::ST_READ: if (rd_cnt_q[4]) state_d = wtol_pkg::ST_LOAD;
      wtol_pkg::ST_LOAD: state_d = wtol_pkg::ST_MUL;
      wtol_pkg::ST_MUL:  state_d = wtol_pkg::ST_ADD;
      wtol_pkg::ST_ADD:  state_d = (hstep_q == 2'd2) ? wtol_pkg::ST_DMUL : wtol_pkg::ST_MUL;
      wtol_pkg::ST_DMUL: state_d = wtol_pkg::ST_DIV;
      wtol_pkg::ST_DIV:  state_d = (grp_q == 2'd3) ? wtol_pkg::ST_MMUL : wtol_pkg::ST_LOAD;
      wtol_pkg::ST_MMUL: state_d = wtol_pkg::ST_MADD;
      wtol_pkg::ST_MADD: state_d = (mstep_q == 2'd2) ? wtol_pkg::ST_OUT : wtol_pkg::ST_MMUL;
      wtol_pkg::ST_OUT:  if (out_free) state_d = wtol_pkg::ST_IDLE;
      default:           state_d = wtol_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operands
  logic signed [wtol_pkg::OpW-1:0] mul_a, mul_b;
  logic                            mul_en;
  logic [wtol_pkg::AccW-1:0]       div_n;
  assign div_n = wtol_pkg::AccW'(acc_q + 3) + wtol_pkg::Div6Bias;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      wtol_pkg::ST_MUL: begin
        mul_en = 1'b1;
        mul_a  = {acc_q[wtol_pkg::AccW-1], acc_q};
        mul_b  = {(wtol_pkg::OpW - wtol_pkg::FracW)'(0), frac_q};
      end
      wtol_pkg::ST_DMUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, div_n};
        mul_b  = wtol_pkg::Div6Mul;
      end
      wtol_pkg::ST_MMUL: begin
        mul_en = 1'b1;
        mul_a  = {mix_hi[wtol_pkg::AccW-1], mix_hi} - {mix_lo[wtol_pkg::AccW-1], mix_lo};
        mul_b  = {(wtol_pkg::OpW - wtol_pkg::LmixW)'(0), mix_w};
      end
      default: ;
    endcase
  end

  // floor shift by 16 of the product, and the quotient by six
  wtol_pkg::acc_t prod_sh, quot6, mix_res;
  assign prod_sh = prod_q[wtol_pkg::AccW+15:16];
  assign quot6   = wtol_pkg::acc_t'(prod_q[wtol_pkg::Div6Shift+wtol_pkg::AccW-1:wtol_pkg::Div6Shift])
                   - wtol_pkg::acc_t'(wtol_pkg::Div6BiasQ);
  assign mix_res = mix_lo + prod_sh;

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    case (state_q)
      wtol_pkg::ST_LOAD: acc_q <= c3;
      wtol_pkg::ST_ADD:  acc_q <= prod_sh + csel;
      wtol_pkg::ST_DIV: begin
        case (grp_q)
          2'd0:    r0_q <= quot6;
          2'd1:    r1_q <= quot6;
          2'd2:    r2_q <= quot6;
          default: r3_q <= quot6;
        endcase
      end
      wtol_pkg::ST_MADD: begin
        case (mstep_q)
          2'd0:    r0_q  <= mix_res;
          2'd1:    r2_q  <= mix_res;
          default: fin_q <= mix_res;
        endcase
      end
      wtol_pkg::ST_IDLE: fin_q <= '0;
      default: ;
    endcase
  end

  // saturation of the final value
  logic signed [wtol_pkg::SampleW-1:0] sat_val;
  always_comb begin
    if (fin_q > wtol_pkg::acc_t'(8388607)) begin
      sat_val = {1'b0, {(wtol_pkg::SampleW-1){1'b1}}};
    end else if (fin_q < wtol_pkg::acc_t'(-8388608)) begin
      sat_val = {1'b1, {(wtol_pkg::SampleW-1){1'b0}}};
    end else begin
      sat_val = fin_q[wtol_pkg::SampleW-1:0];
    end
  end

  // control registers, phase and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wtol_pkg::ST_IDLE;
      phase_q     <= '0;
      idx_q       <= '0;
      frac_q      <= '0;
      rd_cnt_q    <= '0;
      grp_q       <= '0;
      hstep_q     <= '0;
      mstep_q     <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else begin
      state_q <= state_d;
      // a new result loads as the old one leaves, else the register empties on its transfer
      if (state_q == wtol_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        wtol_pkg::ST_IDLE: begin
          rd_cnt_q <= '0;
          grp_q    <= '0;
          hstep_q  <= '0;
          mstep_q  <= '0;
          if (in_xfer && func_i == wtol_pkg::FUNC_PHASE) begin
            phase_q <= phase_value_i;
          end else if (in_xfer && func_i == wtol_pkg::FUNC_TICK && enable_q) begin
            // index and fraction of phase * frame size, then the phase steps on
            idx_q   <= phase_q[wtol_pkg::PhaseW-1 -: wtol_pkg::IdxW];
            frac_q  <= phase_q[wtol_pkg::PhaseW-wtol_pkg::IdxW-1 -: wtol_pkg::FracW];
            phase_q <= phase_q + phase_inc_q;
          end
        end
        wtol_pkg::ST_READ: if (rd_en) rd_cnt_q <= rd_cnt_q + 5'd1;
        wtol_pkg::ST_LOAD: hstep_q <= '0;
        wtol_pkg::ST_ADD:  hstep_q <= hstep_q + 2'd1;
        wtol_pkg::ST_DIV:  grp_q <= grp_q + 2'd1;
        wtol_pkg::ST_MADD: mstep_q <= mstep_q + 2'd1;
        wtol_pkg::ST_OUT: begin
          if (out_free) begin
            sample_q <= sat_val;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // read counter never runs past the sixteen taps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtol_pkg::ST_READ) |-> (rd_cnt_q <= 5'd16))
    else $error("read counter overrun");

  // an accepted tick keeps the input side stalled in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && func_i == wtol_pkg::FUNC_TICK) |=> in_stall_o)
    else $error("tick did not block input");

  // a new result only appears from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == wtol_pkg::ST_OUT))
    else $error("result without finished tick");

  // horner step counter stays within the three steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtol_pkg::ST_ADD) |-> (hstep_q != 2'd3))
    else $error("horner step overrun");
`endif

endmodule
